FILE: hw/rtl/sntp_pkg.sv
package sntp_pkg;

    localparam int CHAR_W          = 8;
    localparam int INT_W           = 32;
    localparam int FRAC_BITS       = 16;
    localparam int MAX_FRAC_DIGITS = 9;
    localparam int FRAC_ACC_W      = 30;
    localparam int FRAC_CNT_W      = 4;
    localparam int MODE_W          = 2;
    localparam int DIV_CNT_W       = $clog2(FRAC_BITS);
    localparam int RES_W           = 1 + INT_W + FRAC_BITS;
    localparam int TDATA_W         = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W           = TDATA_W - RES_W;

    localparam logic [MODE_W-1:0] MODE_DEC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HEX  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FRAC = 2'd2;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

    typedef struct packed {
        logic step;
        logic finish;
        logic div_step;
        logic emit;
    } sntp_cmd_t;

    typedef struct packed {
        logic need_div;
    } sntp_status_t;

    function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] n);
        logic [FRAC_ACC_W-1:0] p;
        case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

FILE: hw/rtl/sntp_datapath.sv
module sntp_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sntp_pkg::MODE_W-1:0]     cfg_wr_data,
    input  logic [sntp_pkg::CHAR_W-1:0]     char_in,
    input  sntp_pkg::sntp_cmd_t             cmd,
    output sntp_pkg::sntp_status_t          status,
    output logic [sntp_pkg::TDATA_W-1:0]    m_tdata,
    output logic                            m_tuser
);

    logic [sntp_pkg::MODE_W-1:0]     mode_reg;

    logic [sntp_pkg::INT_W-1:0]      int_accum_reg, int_accum_next;
    logic [sntp_pkg::FRAC_ACC_W-1:0] frac_accum_reg, frac_accum_next;
    logic [sntp_pkg::FRAC_CNT_W-1:0] frac_cnt_reg, frac_cnt_next;
    logic                            minus_seen_reg, minus_seen_next;
    logic                            digit_seen_reg, digit_seen_next;
    logic                            in_frac_reg, in_frac_next;
    logic                            ended_reg, ended_next;

    logic                            res_found_reg;
    logic                            res_neg_reg;
    logic [sntp_pkg::INT_W-1:0]      res_int_reg;
    logic [sntp_pkg::FRAC_ACC_W-1:0] rem_reg;
    logic [sntp_pkg::FRAC_ACC_W-1:0] divisor_reg;
    logic [sntp_pkg::FRAC_BITS-1:0]  quot_reg;

    logic [sntp_pkg::TDATA_W-1:0]    tdata_reg;
    logic                            tuser_reg;

    logic                            frac_mode;
    logic                            is_dec;
    logic                            is_lhex;
    logic                            is_uhex;
    logic                            is_digit;
    logic [3:0]                      dval;
    logic [sntp_pkg::INT_W-1:0]      int_scaled;
    logic [sntp_pkg::FRAC_ACC_W+3:0] frac_sum;
    logic [sntp_pkg::FRAC_ACC_W:0]   rem_dbl;
    logic                            rem_ge;

    assign frac_mode = (mode_reg == sntp_pkg::MODE_FRAC);
    assign is_dec    = (char_in >= sntp_pkg::CH_ZERO) && (char_in <= sntp_pkg::CH_NINE);
    assign is_lhex   = (mode_reg == sntp_pkg::MODE_HEX) &&
                       (char_in >= sntp_pkg::CH_LA) && (char_in <= sntp_pkg::CH_LF);
    assign is_uhex   = (mode_reg == sntp_pkg::MODE_HEX) &&
                       (char_in >= sntp_pkg::CH_UA) && (char_in <= sntp_pkg::CH_UF);
    assign is_digit  = is_dec || is_lhex || is_uhex;

    always_comb begin
        if (is_lhex) begin
            dval = 4'(char_in - sntp_pkg::CH_LA + 8'd10);
        end else if (is_uhex) begin
            dval = 4'(char_in - sntp_pkg::CH_UA + 8'd10);
        end else begin
            dval = 4'(char_in - sntp_pkg::CH_ZERO);
        end
    end

    assign int_scaled = (mode_reg == sntp_pkg::MODE_HEX) ? {int_accum_reg[27:0], 4'b0}
                      : ({int_accum_reg[28:0], 3'b0} + {int_accum_reg[30:0], 1'b0});
    assign frac_sum   = {1'b0, frac_accum_reg, 3'b0} + {3'b0, frac_accum_reg, 1'b0}
                      + {30'd0, dval};

    always_comb begin
        int_accum_next  = int_accum_reg;
        frac_accum_next = frac_accum_reg;
        frac_cnt_next   = frac_cnt_reg;
        minus_seen_next = minus_seen_reg;
        digit_seen_next = digit_seen_reg;
        in_frac_next    = in_frac_reg;
        ended_next      = ended_reg;
        if (cmd.finish) begin
            int_accum_next  = '0;
            frac_accum_next = '0;
            frac_cnt_next   = '0;
            minus_seen_next = 1'b0;
            digit_seen_next = 1'b0;
            in_frac_next    = 1'b0;
            ended_next      = 1'b0;
        end else if (cmd.step && !ended_reg) begin
            if (is_digit) begin
                if (frac_mode && in_frac_reg) begin
                    if (frac_cnt_reg < sntp_pkg::FRAC_CNT_W'(sntp_pkg::MAX_FRAC_DIGITS)) begin
                        frac_accum_next = frac_sum[sntp_pkg::FRAC_ACC_W-1:0];
                        frac_cnt_next   = frac_cnt_reg + 4'd1;
                    end
                end else begin
                    int_accum_next = int_scaled + {28'd0, dval};
                end
                digit_seen_next = 1'b1;
            end else if (frac_mode && (char_in == sntp_pkg::CH_DOT)) begin
                in_frac_next = 1'b1;
            end else if (digit_seen_reg) begin
                ended_next = 1'b1;
            end else if (char_in == sntp_pkg::CH_MINUS) begin
                minus_seen_next = 1'b1;
            end
        end
    end

    assign status.need_div = digit_seen_reg && frac_mode;

    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_ge  = (rem_dbl >= {1'b0, divisor_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= sntp_pkg::MODE_DEC;
            int_accum_reg  <= '0;
            frac_accum_reg <= '0;
            frac_cnt_reg   <= '0;
            minus_seen_reg <= 1'b0;
            digit_seen_reg <= 1'b0;
            in_frac_reg    <= 1'b0;
            ended_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            int_accum_reg  <= int_accum_next;
            frac_accum_reg <= frac_accum_next;
            frac_cnt_reg   <= frac_cnt_next;
            minus_seen_reg <= minus_seen_next;
            digit_seen_reg <= digit_seen_next;
            in_frac_reg    <= in_frac_next;
            ended_reg      <= ended_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            res_found_reg <= digit_seen_reg;
            res_neg_reg   <= digit_seen_reg && minus_seen_reg;
            if (!digit_seen_reg) begin
                res_int_reg <= '0;
            end else if (minus_seen_reg) begin
                res_int_reg <= '0 - int_accum_reg;
            end else begin
                res_int_reg <= int_accum_reg;
            end
            rem_reg     <= frac_accum_reg;
            divisor_reg <= sntp_pkg::pow10(frac_cnt_reg);
            quot_reg    <= '0;
        end else if (cmd.div_step) begin
            if (rem_ge) begin
                rem_reg <= sntp_pkg::FRAC_ACC_W'(rem_dbl - {1'b0, divisor_reg});
            end else begin
                rem_reg <= rem_dbl[sntp_pkg::FRAC_ACC_W-1:0];
            end
            quot_reg <= {quot_reg[sntp_pkg::FRAC_BITS-2:0], rem_ge};
        end
        if (cmd.emit) begin
            tdata_reg <= {{sntp_pkg::PAD_W{1'b0}}, quot_reg, res_int_reg, res_neg_reg};
            tuser_reg <= res_found_reg;
        end
    end

    assign m_tdata = tdata_reg;
    assign m_tuser = tuser_reg;

endmodule

FILE: hw/rtl/sntp_ctrl.sv
module sntp_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tlast,
    output logic                    s_tready,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    input  sntp_pkg::sntp_status_t  status,
    output sntp_pkg::sntp_cmd_t     cmd
);

    typedef enum logic [1:0] {
        S_RUN,
        S_FINISH,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                           state_reg;
    logic                             m_tvalid_reg;
    logic [sntp_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic                             out_free;

    assign out_free     = !m_tvalid_reg || m_tready;
    assign s_tready     = (state_reg == S_RUN);
    assign m_tvalid     = m_tvalid_reg;

    assign cmd.step     = (state_reg == S_RUN) && s_tvalid;
    assign cmd.finish   = (state_reg == S_FINISH);
    assign cmd.div_step = (state_reg == S_DIV);
    assign cmd.emit     = (state_reg == S_EMIT) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_RUN;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_RUN: begin
                    if (s_tvalid && s_tlast) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (status.need_div) begin
                        cnt_reg   <= sntp_pkg::DIV_CNT_W'(sntp_pkg::FRAC_BITS - 1);
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_EMIT;
                    end
                end
                S_DIV: begin
                    if (cnt_reg == '0) begin
                        state_reg <= S_EMIT;
                    end else begin
                        cnt_reg <= cnt_reg - sntp_pkg::DIV_CNT_W'(1);
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        state_reg <= S_RUN;
                    end
                end
                default: begin
                    state_reg <= S_RUN;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_rise_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result word raised outside emit");

    a_last_to_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == S_FINISH))
        else $error("last character did not start finish");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && cnt_reg == '0) |=> (state_reg == S_EMIT))
        else $error("divider did not hand over to emit");

    a_no_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step || cmd.finish) |-> !(cmd.step && cmd.finish) && !cmd.div_step)
        else $error("overlapping datapath commands");
`endif

endmodule

FILE: hw/rtl/signed_number_text_parser.sv
// Parses one ASCII character per cycle; s_tready stays high through a field.
// After the tlast word, the result passes the finish and emit states in integer modes or
// when no digit was found; in fraction mode the 16-step divider runs between those states.
// Per field, s_tready is low until the result is emitted, also during result-side stalls.
// Reset (aresetn low, synchronous) clears the mode to decimal, the field state and m_tvalid.
module signed_number_text_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sntp_pkg::MODE_W-1:0]     cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sntp_pkg::CHAR_W-1:0]     s_tdata,   // char_in
    input  logic                            s_tlast,   // last_char
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sntp_pkg::TDATA_W-1:0]    m_tdata,   // is_negative, int_value, frac_q16, zero pad
    output logic                            m_tuser    // found_number
);

    sntp_pkg::sntp_cmd_t    cmd;
    sntp_pkg::sntp_status_t status;

    sntp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    sntp_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .char_in     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [sntp_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 25;
    localparam int PHASE_WORDS   = 567;

    typedef struct packed {
        logic                           found;
        logic                           neg;
        logic [sntp_pkg::INT_W-1:0]     ival;
        logic [sntp_pkg::FRAC_BITS-1:0] frac;
    } parse_result_t;

    typedef enum logic {ROW_WORD, ROW_MODE} row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [7:0]    val;
        logic          last;
        logic          typed;
        parse_result_t res;
    } stim_row_t;

    localparam parse_result_t NO_RES = '0;
    localparam int DIR_ROWS = 35;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [sntp_pkg::MODE_W-1:0]   cfg_wr_data = '0;
    logic                          s_tvalid    = 1'b0;
    logic                          s_tready;
    logic [sntp_pkg::CHAR_W-1:0]   s_tdata     = '0;
    logic                          s_tlast     = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready    = 1'b0;
    logic [sntp_pkg::TDATA_W-1:0]  m_tdata;
    logic                          m_tuser;

    // predictor state
    logic [sntp_pkg::MODE_W-1:0]     pmode;
    logic [sntp_pkg::INT_W-1:0]      int_acc;
    logic [sntp_pkg::FRAC_ACC_W-1:0] frac_acc;
    logic [sntp_pkg::FRAC_CNT_W-1:0] frac_cnt;
    logic                            minus_seen;
    logic                            digit_seen;
    logic                            in_frac;
    logic                            num_ended;

    parse_result_t pending_results[$];
    int            mismatch_cnt  = 0;
    int            words_sent    = 0;
    int            send_idle_pct = 0;
    int            rcv_idle_pct  = 0;
    logic          drv_typed     = 1'b0;
    parse_result_t drv_res       = '0;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_WORD, 8'h00,              1'b0, 1'b0, NO_RES},
        '{ROW_WORD, sntp_pkg::CH_MINUS, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "4",                1'b1, 1'b1, '{1'b1, 1'b1, -32'sd4, 16'd0}},
        '{ROW_WORD, "7",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, sntp_pkg::CH_DOT,   1'b0, 1'b0, NO_RES},
        '{ROW_WORD, 8'hFF,              1'b1, 1'b1, '{1'b1, 1'b0, 32'd7, 16'd0}},
        '{ROW_WORD, sntp_pkg::CH_MINUS, 1'b1, 1'b1, '{1'b0, 1'b0, 32'd0, 16'd0}},
        '{ROW_MODE, 8'(sntp_pkg::MODE_HEX), 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, sntp_pkg::CH_MINUS, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "8",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "0",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "0",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "0",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "0",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "0",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "0",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "0",                1'b1, 1'b1, '{1'b1, 1'b1, 32'h8000_0000, 16'd0}},
        '{ROW_MODE, 8'(sntp_pkg::MODE_FRAC), 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, sntp_pkg::CH_MINUS, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, sntp_pkg::CH_MINUS, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, sntp_pkg::CH_DOT,   1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "9",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "9",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "9",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "9",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "9",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "9",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "9",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "9",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "9",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "9",                1'b1, 1'b1, '{1'b1, 1'b1, 32'd0, 16'd65535}},
        '{ROW_WORD, "2",                1'b0, 1'b0, NO_RES},
        '{ROW_WORD, sntp_pkg::CH_DOT,   1'b0, 1'b0, NO_RES},
        '{ROW_MODE, 8'(MODE_SPARE),     1'b0, 1'b0, NO_RES},
        '{ROW_WORD, "5",                1'b1, 1'b0, NO_RES}
    };

    signed_number_text_parser u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    task automatic clear_parse();
        int_acc    = '0;
        frac_acc   = '0;
        frac_cnt   = '0;
        minus_seen = 1'b0;
        digit_seen = 1'b0;
        in_frac    = 1'b0;
        num_ended  = 1'b0;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic last, input logic typed,
                              input parse_result_t typed_res);
        logic          is_digit;
        logic [4:0]    dval;
        logic [63:0]   num;
        logic [63:0]   den;
        parse_result_t r;
        is_digit = 1'b0;
        dval     = '0;
        if (c >= sntp_pkg::CH_ZERO && c <= sntp_pkg::CH_NINE) begin
            is_digit = 1'b1;
            dval     = 5'(c - sntp_pkg::CH_ZERO);
        end else if (pmode == sntp_pkg::MODE_HEX && c >= sntp_pkg::CH_LA &&
                     c <= sntp_pkg::CH_LF) begin
            is_digit = 1'b1;
            dval     = 5'(c - sntp_pkg::CH_LA + 8'd10);
        end else if (pmode == sntp_pkg::MODE_HEX && c >= sntp_pkg::CH_UA &&
                     c <= sntp_pkg::CH_UF) begin
            is_digit = 1'b1;
            dval     = 5'(c - sntp_pkg::CH_UA + 8'd10);
        end
        if (!num_ended) begin
            if (is_digit) begin
                if (pmode == sntp_pkg::MODE_FRAC && in_frac) begin
                    if (frac_cnt < sntp_pkg::MAX_FRAC_DIGITS) begin
                        frac_acc = sntp_pkg::FRAC_ACC_W'(frac_acc * 10 + dval);
                        frac_cnt = frac_cnt + 4'd1;
                    end
                end else begin
                    int_acc = int_acc * ((pmode == sntp_pkg::MODE_HEX) ? 32'd16 : 32'd10)
                            + 32'(dval);
                end
                digit_seen = 1'b1;
            end else if (pmode == sntp_pkg::MODE_FRAC && c == sntp_pkg::CH_DOT) begin
                in_frac = 1'b1;
            end else if (digit_seen) begin
                num_ended = 1'b1;
            end else if (c == sntp_pkg::CH_MINUS) begin
                minus_seen = 1'b1;
            end
        end
        if (last) begin
            r = '0;
            if (digit_seen) begin
                r.found = 1'b1;
                r.neg   = minus_seen;
                r.ival  = minus_seen ? (32'd0 - int_acc) : int_acc;
                if (pmode == sntp_pkg::MODE_FRAC) begin
                    num = 64'(frac_acc) << sntp_pkg::FRAC_BITS;
                    den = 64'd1;
                    for (int i = 0; i < frac_cnt; i++) den = den * 10;
                    r.frac = sntp_pkg::FRAC_BITS'(num / den);
                end
            end
            pending_results.push_back(typed ? typed_res : r);
            clear_parse();
        end
    endtask

    always @(posedge aclk) begin : check_proc
        parse_result_t got;
        parse_result_t want;
        if (!aresetn) begin
            pmode = sntp_pkg::MODE_DEC;
            clear_parse();
        end else begin
            if (m_tvalid && m_tready) begin
                got.found = m_tuser;
                got.neg   = m_tdata[0];
                got.ival  = m_tdata[sntp_pkg::INT_W:1];
                got.frac  = m_tdata[sntp_pkg::INT_W+sntp_pkg::FRAC_BITS:sntp_pkg::INT_W+1];
                if (pending_results.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected result word, int %0d", $realtime,
                                 $signed(got.ival));
                end else begin
                    want = pending_results.pop_front();
                    if (got.found !== want.found || got.neg !== want.neg ||
                        got.ival !== want.ival || got.frac !== want.frac) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("%0t: mismatch exp/act found %0b/%0b neg %0b/%0b",
                                     $realtime, want.found, got.found, want.neg, got.neg);
                            $display("    int %0d/%0d frac %0d/%0d",
                                     $signed(want.ival), $signed(got.ival),
                                     want.frac, got.frac);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                parse_char(s_tdata, s_tlast, drv_typed, drv_res);
            if (cfg_wr_en)
                pmode = cfg_wr_data;
        end
    end

    task automatic send_word(input logic [7:0] c, input logic last, input logic typed,
                             input parse_result_t tres);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= c;
        s_tlast   <= last;
        drv_typed  = typed;
        drv_res    = tres;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        words_sent++;
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_mode(input logic [sntp_pkg::MODE_W-1:0] m);
        wait_results_done();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] digit_char(input logic hex);
        int v;
        v = hex ? $urandom_range(0, 21) : $urandom_range(0, 9);
        if (v < 10) return 8'(sntp_pkg::CH_ZERO + v);
        if (v < 16) return 8'(sntp_pkg::CH_LA + v - 10);
        return 8'(sntp_pkg::CH_UA + v - 16);
    endfunction

    task automatic send_random_field();
        logic [7:0] text[$];
        int         n;
        logic       hex;
        hex = (pmode == sntp_pkg::MODE_HEX);
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) text.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) text.push_back(sntp_pkg::CH_MINUS);
            if ($urandom_range(0, 9) == 0) text.push_back(sntp_pkg::CH_MINUS);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 6);
            if (n == 0 && pmode != sntp_pkg::MODE_FRAC && $urandom_range(0, 3) != 0) n = 1;
            repeat (n) text.push_back(digit_char(hex));
            if (pmode == sntp_pkg::MODE_FRAC && $urandom_range(0, 99) < 80) begin
                text.push_back(sntp_pkg::CH_DOT);
                n = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 6);
                repeat (n) text.push_back(digit_char(1'b0));
                if ($urandom_range(0, 9) == 0) text.push_back(sntp_pkg::CH_DOT);
            end
            repeat ($urandom_range(0, 2)) text.push_back(8'($urandom_range(0, 255)));
        end
        foreach (text[i]) send_word(text[i], i == text.size() - 1, 1'b0, NO_RES);
    endtask

    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stim_proc
        int blk;
        blk = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 15;
        rcv_idle_pct  = 54;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_MODE)
                write_mode(dir_rows[i].val[sntp_pkg::MODE_W-1:0]);
            else
                send_word(dir_rows[i].val, dir_rows[i].last, dir_rows[i].typed,
                          dir_rows[i].res);
        end

        words_sent = 0;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 54 : 0;
            rcv_idle_pct  = (ph == 0) ? 54 : (ph == 1) ? 15 : 0;
            while (words_sent < (ph + 1) * PHASE_WORDS) begin
                write_mode((blk < 4) ? sntp_pkg::MODE_W'(blk)
                                     : sntp_pkg::MODE_W'($urandom_range(0, 3)));
                blk++;
                repeat ($urandom_range(4, 12)) send_random_field();
            end
        end

        wait_results_done();
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
